// ===== sv/cdq_pkg.sv =====
// shared constants, types and index helpers for the ring-store deque
`default_nettype none

package cdq_pkg;

  // store geometry and result limits
  localparam int DEPTH       = 16;
  localparam int MAX_RESULTS = 64;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  // fixed field widths
  localparam int VAL_W  = 32;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;
  localparam int DCNT_W = 7;

  // function codes on the input word
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DUMP_ALL   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_DUMP_N     = 3'd5;

  // status codes on the result word
  localparam logic [STAT_W-1:0] ST_ENTRY = 2'd0;
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // decoded operation
  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_DUMP_ALL,
    OP_DUMP_N,
    OP_NOP
  } op_t;

  // classified command passed from front to back
  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
    logic [RES_W-1:0]        count;
  } cmd_t;

  // ring index plus one, wrapping at the store depth
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    if (idx == IDX_W'(DEPTH - 1)) begin
      return '0;
    end
    return idx + 1'b1;
  endfunction

  // ring index minus one, wrapping at the store depth
  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
    if (idx == '0) begin
      return IDX_W'(DEPTH - 1);
    end
    return idx - 1'b1;
  endfunction

  // ring index plus an offset below the depth
  function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] ofs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(idx) + SUM_W'(ofs);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/cdq_front.sv =====
// input side: decodes each word into a command and queues it for the back end
`default_nettype none

module cdq_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [cdq_pkg::FUNC_W-1:0]      in_func,
  input  wire logic signed [cdq_pkg::VAL_W-1:0] in_value,
  input  wire logic [cdq_pkg::DCNT_W-1:0]      in_dump_count,
  output cdq_pkg::cmd_t                        cmd,
  output logic                                 cmd_valid,
  input  wire logic                            cmd_take
);
  import cdq_pkg::*;

  cmd_t       fifo_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic [1:0] fill_nxt;
  cmd_t       new_cmd;
  logic       in_take;
  logic       pop;

  // classify the incoming word
  always_comb begin
    new_cmd.value = in_value;
    if (in_dump_count > DCNT_W'(MAX_RESULTS)) begin
      new_cmd.count = RES_W'(MAX_RESULTS);
    end else begin
      new_cmd.count = RES_W'(in_dump_count);
    end
    unique case (in_func)
      FUNC_PUSH_FRONT: new_cmd.op = OP_PUSH_FRONT;
      FUNC_PUSH_BACK:  new_cmd.op = OP_PUSH_BACK;
      FUNC_POP_FRONT:  new_cmd.op = OP_POP_FRONT;
      FUNC_POP_BACK:   new_cmd.op = OP_POP_BACK;
      FUNC_DUMP_ALL:   new_cmd.op = OP_DUMP_ALL;
      FUNC_DUMP_N:     new_cmd.op = OP_DUMP_N;
      default:         new_cmd.op = OP_NOP;
    endcase
  end

  // two-entry command queue handshake
  assign in_stall  = (fill_r == 2'd2);
  assign in_take   = in_valid && !in_stall;
  assign cmd_valid = (fill_r != 2'd0);
  assign pop       = cmd_take && cmd_valid;
  assign cmd       = fifo_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (in_take && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (!in_take && pop) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (in_take) begin
      fifo_r[wr_ptr_r] <= new_cmd;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
      if (in_take) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/cdq_back.sv =====
// execution side: ring store, front index, entry count, dump walker, output word
`default_nettype none

module cdq_back (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire cdq_pkg::cmd_t                    cmd,
  input  wire logic                             cmd_valid,
  output logic                                  cmd_take,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [cdq_pkg::VAL_W-1:0]      out_entry_value,
  output logic [cdq_pkg::STAT_W-1:0]            out_status,
  output logic                                  out_last
);
  import cdq_pkg::*;

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  state_t                  state_r;
  logic signed [VAL_W-1:0] ring_mem [DEPTH];
  logic [IDX_W-1:0]        front_r;
  logic [CNT_W-1:0]        count_r;
  logic [IDX_W-1:0]        walk_slot_r;
  logic [CNT_W-1:0]        walk_pos_r;
  logic [RES_W-1:0]        remain_r;
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_entry_r;
  logic [STAT_W-1:0]       out_status_r;
  logic                    out_last_r;

  logic              load_ok;
  logic              start;
  logic              full;
  logic              empty;
  logic              is_push;
  logic              is_pop;
  logic              is_dump;
  logic [RES_W-1:0]  dump_total;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [IDX_W-1:0]  cur_slot;
  logic [CNT_W-1:0]  cur_pos;
  logic [IDX_W-1:0]  adv_slot;
  logic [CNT_W-1:0]  adv_pos;
  logic              emit_entry;
  logic              load_any;
  logic [STAT_W-1:0] start_status;
  logic              start_last;

  // output register frees when empty or being taken
  assign load_ok  = !out_valid_r || !out_stall;
  assign cmd_take = (state_r == S_IDLE) && load_ok;
  assign start    = cmd_take && cmd_valid;

  // command decode against current occupancy
  always_comb begin
    full       = (count_r == CNT_W'(DEPTH));
    empty      = (count_r == '0);
    is_push    = (cmd.op == OP_PUSH_FRONT) || (cmd.op == OP_PUSH_BACK);
    is_pop     = (cmd.op == OP_POP_FRONT) || (cmd.op == OP_POP_BACK);
    is_dump    = (cmd.op == OP_DUMP_ALL) || (cmd.op == OP_DUMP_N);
    dump_total = (cmd.op == OP_DUMP_ALL) ? RES_W'(count_r) : cmd.count;
    mem_we     = start && is_push && !full;
    mem_waddr  = (cmd.op == OP_PUSH_FRONT) ? idx_dec(front_r) : idx_add(front_r, count_r);
  end

  // status and last flag of the first word a new command loads
  always_comb begin
    start_status = ST_DONE;
    start_last   = 1'b1;
    if (is_push && full) begin
      start_status = ST_FULL;
    end else if ((is_pop || is_dump) && empty) begin
      start_status = ST_EMPTY;
    end else if (is_dump && (dump_total != '0)) begin
      start_status = ST_ENTRY;
      start_last   = (dump_total == RES_W'(1));
    end
  end

  // dump walker: position wraps to the front after the back entry
  always_comb begin
    if (state_r == S_IDLE) begin
      cur_slot = front_r;
      cur_pos  = '0;
    end else begin
      cur_slot = walk_slot_r;
      cur_pos  = walk_pos_r;
    end
    if (cur_pos + 1'b1 == count_r) begin
      adv_slot = front_r;
      adv_pos  = '0;
    end else begin
      adv_slot = idx_inc(cur_slot);
      adv_pos  = cur_pos + 1'b1;
    end
  end

  // what goes into the output word this cycle
  always_comb begin
    load_any   = start || ((state_r == S_DUMP) && load_ok);
    emit_entry = ((state_r == S_DUMP) && load_ok) ||
                 (start && is_dump && !empty && (dump_total != '0));
  end

  // ring store and entry value of the output word
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= cmd.value;
    end
    if (emit_entry) begin
      out_entry_r <= ring_mem[cur_slot];
    end else if (load_any) begin
      out_entry_r <= '0;
    end
  end

  // sequencer, queue pointers and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      front_r     <= '0;
      count_r     <= '0;
    end else begin
      if (out_valid_r && !out_stall && !load_any) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            out_valid_r  <= 1'b1;
            out_last_r   <= start_last;
            out_status_r <= start_status;
            unique case (cmd.op)
              OP_PUSH_FRONT: begin
                if (!full) begin
                  front_r <= idx_dec(front_r);
                  count_r <= count_r + 1'b1;
                end
              end
              OP_PUSH_BACK: begin
                if (!full) begin
                  count_r <= count_r + 1'b1;
                end
              end
              OP_POP_FRONT: begin
                if (!empty) begin
                  front_r <= idx_inc(front_r);
                  count_r <= count_r - 1'b1;
                end
              end
              OP_POP_BACK: begin
                if (!empty) begin
                  count_r <= count_r - 1'b1;
                end
              end
              OP_DUMP_ALL, OP_DUMP_N: begin
                if (!empty && (dump_total != '0)) begin
                  // first entry goes out now, the walker takes the rest
                  remain_r    <= dump_total - 1'b1;
                  walk_slot_r <= adv_slot;
                  walk_pos_r  <= adv_pos;
                  if (dump_total != RES_W'(1)) begin
                    state_r <= S_DUMP;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DUMP: begin
          if (load_ok) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_ENTRY;
            out_last_r   <= (remain_r == RES_W'(1));
            remain_r     <= remain_r - 1'b1;
            walk_slot_r  <= adv_slot;
            walk_pos_r   <= adv_pos;
            if (remain_r == RES_W'(1)) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry_value = out_entry_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

// ===== sv/circular_deque_ring_store.sv =====
// top level of the bounded double-ended queue held in a ring store
//
//  channel  direction  handshake         payload
//  in_      input      valid / stall     func, value, dump_count
//  out_     output     valid / stall     entry_value, status, last
//
// push, pop and unused codes give one result word per cycle once the queue is primed, while out_stall is low
// dump all gives one entry word per live entry, dump n gives min(dump_count, 64) entry words:
//   the walker reads one ring entry per cycle through the single read port while the output is not stalled
// a word is registered in the two-entry command queue before execution
// reset is synchronous, active low; ring contents are not cleared, no sweep after reset
// out_stall holds the output word; the command queue keeps taking input until full
`default_nettype none

module circular_deque_ring_store (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [cdq_pkg::FUNC_W-1:0]       in_func,
  input  wire logic signed [cdq_pkg::VAL_W-1:0] in_value,
  input  wire logic [cdq_pkg::DCNT_W-1:0]       in_dump_count,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [cdq_pkg::VAL_W-1:0]      out_entry_value,
  output logic [cdq_pkg::STAT_W-1:0]            out_status,
  output logic                                  out_last
);
  import cdq_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;

  // decode and queue
  cdq_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_value      (in_value),
    .in_dump_count (in_dump_count),
    .cmd           (cmd),
    .cmd_valid     (cmd_valid),
    .cmd_take      (cmd_take)
  );

  // execute against the ring store
  cdq_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cmd_valid       (cmd_valid),
    .cmd_take        (cmd_take),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_entry_value (out_entry_value),
    .out_status      (out_status),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

// ===== sv/cdq_checker.sv =====
// port-level checks for the ring-store deque, bound to the top level
`default_nettype none

module cdq_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic signed [cdq_pkg::VAL_W-1:0] out_entry_value,
  input wire logic [cdq_pkg::STAT_W-1:0]       out_status,
  input wire logic                             out_last
);
  import cdq_pkg::*;

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_entry_value) &&
                               $stable(out_status) && $stable(out_last))
    else $error("output word changed under stall");

  // only emitted entries carry a value
  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_ENTRY) |-> (out_entry_value == '0))
    else $error("non-entry word carries a value");

  // every non-entry status is the sole word of its input
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_ENTRY) |-> out_last)
    else $error("status word not marked last");

  // reset empties the output and opens the input
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output or stall not cleared by reset");

endmodule

bind circular_deque_ring_store cdq_checker u_cdq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_entry_value (out_entry_value),
  .out_status      (out_status),
  .out_last        (out_last)
);

`default_nettype wire

// ===== dv/deque_ring_checker.sv =====
// checker for the ring-store deque: predicts result words and compares them as they leave
`default_nettype none

module deque_ring_checker
  import cdq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic                     in_stall,
  input  wire logic [FUNC_W-1:0]        in_func,
  input  wire logic signed [VAL_W-1:0]  in_value,
  input  wire logic [DCNT_W-1:0]        in_dump_count,
  input  wire logic                     out_valid,
  input  wire logic                     out_stall,
  input  wire logic signed [VAL_W-1:0]  out_entry_value,
  input  wire logic [STAT_W-1:0]        out_status,
  input  wire logic                     out_last,
  output int                            fail_count,
  output int                            pending_words
);

  // one result word as it should leave the block
  typedef struct packed {
    logic signed [VAL_W-1:0] entry;
    logic [STAT_W-1:0]       status;
    logic                    last;
  } deque_word_t;

  // private copy of the deque contents
  logic signed [VAL_W-1:0] ring_copy [DEPTH];
  int                      head_slot;
  int                      occupancy;
  deque_word_t             expected_words [$];

  // queue one expected word
  task automatic queue_word(input logic signed [VAL_W-1:0] entry,
                            input logic [STAT_W-1:0] status, input logic last);
    deque_word_t w;
    w.entry  = entry;
    w.status = status;
    w.last   = last;
    expected_words.push_back(w);
  endtask

  // apply one operation to the copy and queue the words it causes
  task automatic predict_deque_words(input logic [FUNC_W-1:0] func,
                                     input logic signed [VAL_W-1:0] value,
                                     input logic [DCNT_W-1:0] dump_count);
    int burst;
    case (func)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (occupancy >= DEPTH) begin
          queue_word('0, ST_FULL, 1'b1);
        end else begin
          if (func == FUNC_PUSH_FRONT) begin
            head_slot = (head_slot + DEPTH - 1) % DEPTH;
            ring_copy[head_slot] = value;
          end else begin
            ring_copy[(head_slot + occupancy) % DEPTH] = value;
          end
          occupancy++;
          queue_word('0, ST_DONE, 1'b1);
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK: begin
        if (occupancy == 0) begin
          queue_word('0, ST_EMPTY, 1'b1);
        end else begin
          if (func == FUNC_POP_FRONT) head_slot = (head_slot + 1) % DEPTH;
          occupancy--;
          queue_word('0, ST_DONE, 1'b1);
        end
      end
      FUNC_DUMP_ALL, FUNC_DUMP_N: begin
        if (occupancy == 0) begin
          queue_word('0, ST_EMPTY, 1'b1);
        end else begin
          // dump n saturates at the result limit and wraps around the live entries
          if (func == FUNC_DUMP_ALL) burst = occupancy;
          else burst = (int'(dump_count) > MAX_RESULTS) ? MAX_RESULTS : int'(dump_count);
          if (burst == 0) begin
            queue_word('0, ST_DONE, 1'b1);
          end else begin
            for (int i = 0; i < burst; i++) begin
              queue_word(ring_copy[(head_slot + (i % occupancy)) % DEPTH], ST_ENTRY,
                         i == burst - 1);
            end
          end
        end
      end
      // spare codes do nothing
      default: queue_word('0, ST_DONE, 1'b1);
    endcase
  endtask

  // count a failure, print only the first few
  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // watch both channels at the rising edge
  always @(posedge clk) begin : watch
    deque_word_t want;
    if (!rst_n) begin
      head_slot = 0;
      occupancy = 0;
      expected_words.delete();
    end else begin
      if (in_valid && !in_stall) predict_deque_words(in_func, in_value, in_dump_count);
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          note_failure($sformatf("unexpected word: value %0d status %0d last %0b",
                                 out_entry_value, out_status, out_last));
        end else begin
          want = expected_words.pop_front();
          if (out_entry_value !== want.entry || out_status !== want.status ||
              out_last !== want.last) begin
            note_failure($sformatf(
              "mismatch: expected value %0d status %0d last %0b, got value %0d status %0d last %0b",
              want.entry, want.status, want.last, out_entry_value, out_status, out_last));
          end
        end
      end
    end
    pending_words = expected_words.size();
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// top of the deque testbench: clock, reset, stimulus and verdict
`default_nettype none

module testbench;
  import cdq_pkg::*;

  // spare function codes, answered with done
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [FUNC_W-1:0]       in_func;
  logic signed [VAL_W-1:0] in_value;
  logic [DCNT_W-1:0]       in_dump_count;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [VAL_W-1:0] out_entry_value;
  logic [STAT_W-1:0]       out_status;
  logic                    out_last;
  int                      fail_count;
  int                      pending_words;
  int                      send_idle_pct;
  int                      recv_stall_pct;

  always #5 clk = ~clk;

  circular_deque_ring_store DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_value       (in_value),
    .in_dump_count  (in_dump_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_entry_value(out_entry_value),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  deque_ring_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_value       (in_value),
    .in_dump_count  (in_dump_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_entry_value(out_entry_value),
    .out_status     (out_status),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .pending_words  (pending_words)
  );

  // receiver back-pressure, changed at the falling edge
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // hand one input word over, with random idle cycles ahead of it
  task automatic send_word(input logic [FUNC_W-1:0] func,
                           input logic signed [VAL_W-1:0] value,
                           input logic [DCNT_W-1:0] dump_count);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= func;
    in_value      <= value;
    in_dump_count <= dump_count;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // hold off input until every expected word has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_words != 0) @(negedge clk);
  endtask

  // corner cases: empty store, spare codes, extremes, full store, saturated dump
  task automatic directed_words();
    send_word(FUNC_POP_FRONT, 32'sd5, 7'd0);
    send_word(FUNC_POP_BACK, 32'sd5, 7'd0);
    send_word(FUNC_DUMP_ALL, 32'sd0, 7'd0);
    send_word(FUNC_DUMP_N, 32'sd0, 7'd0);
    send_word(FUNC_DUMP_N, 32'sd0, 7'd3);
    send_word(FUNC_SPARE_LO, -32'sd1, 7'h7F);
    send_word(FUNC_SPARE_HI, 32'sd0, 7'd0);
    send_word(FUNC_PUSH_FRONT, 32'sh7FFF_FFFF, 7'd0);
    send_word(FUNC_PUSH_BACK, 32'sh8000_0000, 7'h7F);
    send_word(FUNC_DUMP_N, 32'sd0, 7'd0);
    send_word(FUNC_DUMP_N, 32'sd0, 7'h7F);
    // fill to the brim from both ends
    for (int i = 0; i < DEPTH - 2; i++) begin
      send_word(i[0] ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT,
                (i == 0) ? -32'sd1 : signed'($urandom), 7'd0);
    end
    send_word(FUNC_PUSH_FRONT, 32'sd1, 7'd0);
    send_word(FUNC_PUSH_BACK, 32'sd2, 7'd0);
    send_word(FUNC_DUMP_ALL, 32'sd0, 7'd0);
    send_word(FUNC_DUMP_N, 32'sd0, 7'd64);
    send_word(FUNC_POP_FRONT, 32'sd0, 7'd0);
    send_word(FUNC_POP_BACK, 32'sd0, 7'd0);
  endtask

  // random words, alternating stretches that grow and shrink the deque
  task automatic random_words(input int count);
    int                      roll;
    int                      push_cut;
    int                      pop_cut;
    logic [FUNC_W-1:0]       func;
    logic signed [VAL_W-1:0] value;
    logic [DCNT_W-1:0]       dump_count;
    for (int k = 0; k < count; k++) begin
      push_cut = ((k / 30) % 2 == 0) ? 75 : 15;
      pop_cut  = push_cut + (((k / 30) % 2 == 0) ? 10 : 50);
      roll = $urandom_range(99);
      if (roll < push_cut) func = $urandom_range(1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
      else if (roll < pop_cut) func = $urandom_range(1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
      else if (roll < 96) func = $urandom_range(1) ? FUNC_DUMP_N : FUNC_DUMP_ALL;
      else func = $urandom_range(1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
      case ($urandom_range(7))
        0: value = 32'sh8000_0000;
        1: value = 32'sh7FFF_FFFF;
        default: value = signed'($urandom);
      endcase
      case ($urandom_range(9))
        0: dump_count = DCNT_W'($urandom_range(64, 127));
        1: dump_count = '0;
        default: dump_count = DCNT_W'($urandom_range(1, 20));
      endcase
      send_word(func, value, dump_count);
    end
  endtask

  // stimulus and verdict
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = '0;
    in_value       = '0;
    in_dump_count  = '0;
    send_idle_pct  = 31;
    recv_stall_pct = 85;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_words();
    random_words(40);
    drain_results();

    send_idle_pct  = 85;
    recv_stall_pct = 31;
    random_words(40);
    drain_results();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_words(40);
    drain_results();

    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/cdq_pkg.sv
sv/cdq_front.sv
sv/cdq_back.sv
sv/circular_deque_ring_store.sv
sv/cdq_checker.sv
dv/deque_ring_checker.sv
dv/testbench.sv
